// ----- sv/assert_macros.svh -----
// Assertion macros shared by the delayed coincidence search RTL.
// Expects a clock named aclk and an active-low reset named aresetn in scope.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Property checked at every clock edge outside reset.
`define ASSERT_ALWAYS(label, prop, msg) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) (prop)) else $error(msg);

// Consequent checked in the cycle after the antecedent.
`define ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ----- sv/dcs_pkg.sv -----
// Package for the delayed coincidence search: field widths, defaults, register codes.
// No dependencies.
`timescale 1ns / 1ps

package dcs_pkg;

    localparam int STORE_DEPTH_DEF    = 64;
    localparam int DETECTOR_COUNT_DEF = 64;

    localparam int EVENT_W  = 32;
    localparam int CHAN_W   = 12;
    localparam int DET_W    = 6;
    localparam int ENERGY_W = 18;
    localparam int TIME_W   = 48;

    // one stored hit: event, channel, energy, time from the lowest bit up
    localparam int HIT_W = EVENT_W + CHAN_W + ENERGY_W + TIME_W;

    localparam int S_TDATA_W = 120;
    localparam int M_TDATA_W = 224;

    localparam int CFG_ADDR_W = 2;
    localparam int CFG_DATA_W = 64;

    localparam logic [ENERGY_W-1:0] FIVE_KEV = 18'd80;

    typedef enum logic [CFG_ADDR_W-1:0] {
        CFG_TRIGGER_ENERGY    = 2'd0,
        CFG_PROMPT_MAX_ENERGY = 2'd1,
        CFG_WINDOW_TICKS      = 2'd2,
        CFG_GOOD_DET_MASK     = 2'd3
    } cfg_reg_t;

endpackage

// ----- sv/dcs_ram.sv -----
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
`timescale 1ns / 1ps

module dcs_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 64
) (
    input  logic                     aclk,
    input  logic                     wr_en,
    input  logic [$clog2(DEPTH)-1:0] wr_addr,
    input  logic [WIDTH-1:0]         wr_data,
    input  logic                     rd_en,
    input  logic [$clog2(DEPTH)-1:0] rd_addr,
    output logic [WIDTH-1:0]         rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rd_data_reg;

    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en) begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

// ----- sv/delayed_coincidence_search_top.sv -----
// Ordinary hit: accepted in IDLE, stored in the next cycle in STORE; then ready again in IDLE.
// Trigger hit: READ, DIFF and WIN per store entry walked, then FLUSH and STORE, plus output stalls.
// The walk is set by the single read port of the hit store and one shared 48-bit compare.
// Results are held in an output register; one pending pair is kept to mark the last one.
// Reset (aresetn, synchronous, active low) clears state, write pointer, fill count and config.
// Hit store contents are not cleared; only entries already written are ever read.
`timescale 1ns / 1ps
`include "assert_macros.svh"

module delayed_coincidence_search_top #(
    parameter int STORE_DEPTH    = dcs_pkg::STORE_DEPTH_DEF,
    parameter int DETECTOR_COUNT = dcs_pkg::DETECTOR_COUNT_DEF
) (
    input  logic                            aclk,
    input  logic                            aresetn,
    // event_number, channel, detector_index, energy, event_time, zero pad
    input  logic [dcs_pkg::S_TDATA_W-1:0]   s_tdata,
    // event_clean
    input  logic                            s_tuser,
    input  logic                            s_tvalid,
    output logic                            s_tready,
    // trigger_event, trigger_channel, trigger_energy_out, trigger_time,
    // prompt_event, prompt_channel, prompt_energy, prompt_time, zero pad
    output logic [dcs_pkg::M_TDATA_W-1:0]   m_tdata,
    output logic                            m_tlast,
    output logic                            m_tvalid,
    input  logic                            m_tready,
    input  logic                            cfg_wr_en,
    input  logic [dcs_pkg::CFG_ADDR_W-1:0]  cfg_addr,
    input  logic [dcs_pkg::CFG_DATA_W-1:0]  cfg_data
);

    localparam int PTR_W  = (STORE_DEPTH > 1) ? $clog2(STORE_DEPTH) : 1;
    localparam int FILL_W = $clog2(STORE_DEPTH + 1);
    localparam int EV_W   = dcs_pkg::EVENT_W;
    localparam int CH_W   = dcs_pkg::CHAN_W;
    localparam int EN_W   = dcs_pkg::ENERGY_W;
    localparam int TM_W   = dcs_pkg::TIME_W;
    localparam int HIT_W  = dcs_pkg::HIT_W;
    localparam int PAD_W  = dcs_pkg::M_TDATA_W - 2 * HIT_W;

    typedef enum logic [5:0] {
        ST_IDLE  = 6'b000001,
        ST_READ  = 6'b000010,
        ST_DIFF  = 6'b000100,
        ST_WIN   = 6'b001000,
        ST_FLUSH = 6'b010000,
        ST_STORE = 6'b100000
    } state_t;

    state_t state_reg, state_next;

    logic [EN_W-1:0]           trig_energy_reg;
    logic [EN_W-1:0]           prompt_max_reg;
    logic [TM_W-1:0]           window_reg;
    logic [DETECTOR_COUNT-1:0] good_mask_reg;

    logic [EV_W-1:0] hit_ev_reg, hit_ev_next;
    logic [CH_W-1:0] hit_ch_reg, hit_ch_next;
    logic [EN_W-1:0] hit_en_reg, hit_en_next;
    logic [TM_W-1:0] hit_tm_reg, hit_tm_next;
    logic            store_flag_reg, store_flag_next;

    logic [PTR_W-1:0]  wp_reg, wp_next;
    logic [FILL_W-1:0] fill_count_reg, fill_count_next;
    logic [PTR_W-1:0]  idx_reg, idx_next;
    logic [FILL_W-1:0] k_reg, k_next;

    logic [TM_W-1:0] dt_reg, dt_next;
    logic            ev_lt_reg, ev_lt_next;

    logic [HIT_W-1:0] pend_reg, pend_next;
    logic             pend_valid_reg, pend_valid_next;

    logic [dcs_pkg::M_TDATA_W-1:0] m_tdata_reg, m_tdata_next;
    logic                          m_tlast_reg, m_tlast_next;
    logic                          m_tvalid_reg, m_tvalid_next;

    // input fields
    logic [EV_W-1:0]           in_ev;
    logic [CH_W-1:0]           in_ch;
    logic [dcs_pkg::DET_W-1:0] in_det;
    logic [EN_W-1:0]           in_en;
    logic [TM_W-1:0]           in_tm;
    logic [EN_W-1:0]           in_de;
    logic [63:0]               mask_ext;
    logic                      in_good;
    logic                      in_base;
    logic                      in_trig;

    logic [HIT_W-1:0] rd_data;
    logic [EV_W-1:0]  rd_ev;
    logic [TM_W-1:0]  rd_tm;
    logic [TM_W:0]    diff_ab;
    logic [TM_W:0]    diff_ba;

    logic             ram_rd_en;
    logic             ram_wr_en;
    logic             out_free;
    logic             out_load;
    logic             out_last;
    logic [PTR_W-1:0] idx_prev;
    logic             walk_done;

    assign in_ev  = s_tdata[31:0];
    assign in_ch  = s_tdata[43:32];
    assign in_det = s_tdata[49:44];
    assign in_en  = s_tdata[67:50];
    assign in_tm  = s_tdata[115:68];

    assign in_de    = (in_en > trig_energy_reg) ? (in_en - trig_energy_reg)
                                                : (trig_energy_reg - in_en);
    assign mask_ext = 64'(good_mask_reg);
    assign in_good  = ({1'b0, in_det} < 7'(DETECTOR_COUNT)) && mask_ext[in_det];
    assign in_base  = s_tuser && !in_ch[0];
    assign in_trig  = in_base && (in_de < dcs_pkg::FIVE_KEV);

    assign rd_ev   = rd_data[EV_W-1:0];
    assign rd_tm   = rd_data[HIT_W-1 -: TM_W];
    assign diff_ab = {1'b0, hit_tm_reg} - {1'b0, rd_tm};
    assign diff_ba = {1'b0, rd_tm} - {1'b0, hit_tm_reg};

    assign idx_prev  = (idx_reg == '0) ? PTR_W'(STORE_DEPTH - 1) : (idx_reg - PTR_W'(1));
    assign walk_done = (k_reg + FILL_W'(1)) == fill_count_reg;
    assign out_free  = !m_tvalid_reg || m_tready;

    dcs_ram #(
        .WIDTH (HIT_W),
        .DEPTH (STORE_DEPTH)
    ) u_store (
        .aclk    (aclk),
        .wr_en   (ram_wr_en),
        .wr_addr (wp_reg),
        .wr_data ({hit_tm_reg, hit_en_reg, hit_ch_reg, hit_ev_reg}),
        .rd_en   (ram_rd_en),
        .rd_addr (idx_reg),
        .rd_data (rd_data)
    );

    always_comb begin
        state_next      = state_reg;
        hit_ev_next     = hit_ev_reg;
        hit_ch_next     = hit_ch_reg;
        hit_en_next     = hit_en_reg;
        hit_tm_next     = hit_tm_reg;
        store_flag_next = store_flag_reg;
        wp_next         = wp_reg;
        fill_count_next = fill_count_reg;
        idx_next        = idx_reg;
        k_next          = k_reg;
        dt_next         = dt_reg;
        ev_lt_next      = ev_lt_reg;
        pend_next       = pend_reg;
        pend_valid_next = pend_valid_reg;
        ram_rd_en       = 1'b0;
        ram_wr_en       = 1'b0;
        out_load        = 1'b0;
        out_last        = 1'b0;
        s_tready        = 1'b0;

        unique case (state_reg)
            ST_IDLE: begin
                s_tready = 1'b1;
                if (s_tvalid) begin
                    hit_ev_next     = in_ev;
                    hit_ch_next     = in_ch;
                    hit_en_next     = in_en;
                    hit_tm_next     = in_tm;
                    store_flag_next = in_base && in_good && (in_en > dcs_pkg::FIVE_KEV)
                                      && (in_en < prompt_max_reg);
                    idx_next        = (wp_reg == '0) ? PTR_W'(STORE_DEPTH - 1)
                                                     : (wp_reg - PTR_W'(1));
                    k_next          = '0;
                    if (in_trig && (fill_count_reg != '0)) begin
                        state_next = ST_READ;
                    end else begin
                        state_next = ST_STORE;
                    end
                end
            end
            ST_READ: begin
                ram_rd_en  = 1'b1;
                state_next = ST_DIFF;
            end
            ST_DIFF: begin
                ev_lt_next = rd_ev < hit_ev_reg;
                dt_next    = diff_ab[TM_W] ? diff_ba[TM_W-1:0] : diff_ab[TM_W-1:0];
                state_next = ST_WIN;
            end
            ST_WIN: begin
                priority if (ev_lt_reg && (dt_reg >= window_reg)) begin
                    state_next = ST_FLUSH;
                end else if (ev_lt_reg && pend_valid_reg && !out_free) begin
                    state_next = ST_WIN;
                end else begin
                    if (ev_lt_reg) begin
                        out_load        = pend_valid_reg;
                        pend_next       = rd_data;
                        pend_valid_next = 1'b1;
                    end
                    if (walk_done) begin
                        state_next = ST_FLUSH;
                    end else begin
                        k_next     = k_reg + FILL_W'(1);
                        idx_next   = idx_prev;
                        state_next = ST_READ;
                    end
                end
            end
            ST_FLUSH: begin
                if (!pend_valid_reg) begin
                    state_next = ST_STORE;
                end else if (out_free) begin
                    out_load        = 1'b1;
                    out_last        = 1'b1;
                    pend_valid_next = 1'b0;
                    state_next      = ST_STORE;
                end
            end
            ST_STORE: begin
                if (store_flag_reg) begin
                    ram_wr_en = 1'b1;
                    wp_next   = (wp_reg == PTR_W'(STORE_DEPTH - 1)) ? '0
                                                                   : (wp_reg + PTR_W'(1));
                    if (fill_count_reg != FILL_W'(STORE_DEPTH)) begin
                        fill_count_next = fill_count_reg + FILL_W'(1);
                    end
                end
                state_next = ST_IDLE;
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_comb begin
        m_tdata_next  = m_tdata_reg;
        m_tlast_next  = m_tlast_reg;
        m_tvalid_next = m_tvalid_reg;
        if (out_load) begin
            m_tdata_next  = {PAD_W'(0), pend_reg, hit_tm_reg, hit_en_reg, hit_ch_reg,
                             hit_ev_reg};
            m_tlast_next  = out_last;
            m_tvalid_next = 1'b1;
        end else if (m_tready) begin
            m_tvalid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg       <= ST_IDLE;
            trig_energy_reg <= '0;
            prompt_max_reg  <= '0;
            window_reg      <= '0;
            good_mask_reg   <= '0;
            wp_reg          <= '0;
            fill_count_reg  <= '0;
            pend_valid_reg  <= 1'b0;
            m_tvalid_reg    <= 1'b0;
        end else begin
            state_reg      <= state_next;
            wp_reg         <= wp_next;
            fill_count_reg <= fill_count_next;
            pend_valid_reg <= pend_valid_next;
            m_tvalid_reg   <= m_tvalid_next;
            if (cfg_wr_en) begin
                unique case (dcs_pkg::cfg_reg_t'(cfg_addr))
                    dcs_pkg::CFG_TRIGGER_ENERGY:    trig_energy_reg <= cfg_data[EN_W-1:0];
                    dcs_pkg::CFG_PROMPT_MAX_ENERGY: prompt_max_reg  <= cfg_data[EN_W-1:0];
                    dcs_pkg::CFG_WINDOW_TICKS:      window_reg      <= cfg_data[TM_W-1:0];
                    dcs_pkg::CFG_GOOD_DET_MASK: begin
                        good_mask_reg <= cfg_data[DETECTOR_COUNT-1:0];
                    end
                    default: begin
                        trig_energy_reg <= trig_energy_reg;
                    end
                endcase
            end
        end
    end

    always_ff @(posedge aclk) begin
        hit_ev_reg     <= hit_ev_next;
        hit_ch_reg     <= hit_ch_next;
        hit_en_reg     <= hit_en_next;
        hit_tm_reg     <= hit_tm_next;
        store_flag_reg <= store_flag_next;
        idx_reg        <= idx_next;
        k_reg          <= k_next;
        dt_reg         <= dt_next;
        ev_lt_reg      <= ev_lt_next;
        pend_reg       <= pend_next;
        m_tdata_reg    <= m_tdata_next;
        m_tlast_reg    <= m_tlast_next;
    end

    assign m_tdata  = m_tdata_reg;
    assign m_tlast  = m_tlast_reg;
    assign m_tvalid = m_tvalid_reg;

    `ASSERT_ALWAYS(a_fill_bound, fill_count_reg <= FILL_W'(STORE_DEPTH), "fill count overrun")
    `ASSERT_ALWAYS(a_wp_range, wp_reg < PTR_W'(STORE_DEPTH - 1) || wp_reg == PTR_W'(STORE_DEPTH - 1), "write pointer out of range")
    `ASSERT_ALWAYS(a_idle_no_pend, !(state_reg == ST_IDLE && pend_valid_reg), "pair left pending at idle")
    `ASSERT_ALWAYS(a_walk_nonempty, !(state_reg == ST_READ && fill_count_reg == '0), "walk over empty store")
    `ASSERT_NEXT(a_fill_step, ram_wr_en, (fill_count_reg == $past(fill_count_reg) + FILL_W'(1)) || (fill_count_reg == FILL_W'(STORE_DEPTH)), "fill count not advanced on store")

endmodule
